@@ rtl/pts_pkg.sv @@
// Shared constants, codes and payload types of the periodic task scheduler.
package pts_pkg;

    localparam int MAX_TASKS = 16;
    localparam int ID_W      = 4;
    localparam int ID_COUNT  = 1 << ID_W;
    localparam int TICK_W    = 32;
    localparam int POS_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W     = $clog2(MAX_TASKS + 1);

    localparam logic [2:0] OP_TICK    = 3'd0;
    localparam logic [2:0] OP_REG     = 3'd1;
    localparam logic [2:0] OP_UNREG   = 3'd2;
    localparam logic [2:0] OP_SET_EN  = 3'd3;
    localparam logic [2:0] OP_SET_PER = 3'd4;

    localparam logic [1:0] K_STATUS = 2'd0;
    localparam logic [1:0] K_FIRED  = 2'd1;
    localparam logic [1:0] K_END    = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    typedef struct packed {
        logic [2:0]        opcode;
        logic [ID_W-1:0]   task_id;
        logic [TICK_W-1:0] period;
        logic              enable;
        logic [TICK_W-1:0] tick_now;
    } t_req;

    typedef struct packed {
        logic [1:0]        kind;
        logic [ID_W-1:0]   fired_task;
        logic [TICK_W-1:0] lateness;
        logic [1:0]        status;
        logic              last;
    } t_res;

    typedef struct packed {
        logic              enable;
        logic [TICK_W-1:0] period;
        logic [TICK_W-1:0] last_fire;
    } t_task;

    typedef enum logic [1:0] {
        S_IDLE,
        S_UPDATE,
        S_UNREG,
        S_TICK
    } t_state;

endpackage

@@ rtl/pts_ram.sv @@
// Simple dual-port RAM with one write port and one registered read port.
module pts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/periodic_task_scheduler_top.sv @@
// Top level of the periodic task scheduler: control sequencer around two task memories.
//
//  channel   direction  handshake                    payload
//  request   in         start high while busy low    i_req   (pts_pkg::t_req)
//  result    out        o_res_valid, one cycle       o_res   (pts_pkg::t_res)
//  config    in         i_cfg_valid and o_cfg_ready  i_cfg_data (first_only)
//
// Status requests answer in the cycle after acceptance; register of a known task, set_enable
// and set_period read the task entry in idle, then write it back in the update state.
// Unregister makes one order-memory read per cycle while later
// entries move up one place. A tick makes one order-memory read per cycle, feeding a read,
// elapsed, compare-and-write path of three stages.
// Reset empties the table at once through the presence bits; no memory clearing pass.
// Results cannot be stalled; busy stays high until the final result has been registered.
module periodic_task_scheduler_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  pts_pkg::t_req i_req,
    output logic          o_res_valid,
    output pts_pkg::t_res o_res,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic          i_cfg_data
);

    pts_pkg::t_state r_state, n_state;
    pts_pkg::t_req   r_req, n_req;
    logic [pts_pkg::CNT_W-1:0]    r_count, n_count;
    logic [pts_pkg::ID_COUNT-1:0] r_present, n_present;
    logic                         r_first_only;
    logic [pts_pkg::CNT_W-1:0]    r_idx, n_idx;
    logic                         r_s1_v, n_s1_v;
    logic [pts_pkg::POS_W-1:0]    r_s1_pos, n_s1_pos;
    logic                         r_found, n_found;
    logic                         r_s2_v, n_s2_v;
    logic [pts_pkg::ID_W-1:0]     r_s2_id, n_s2_id;
    logic                         r_s3_v, n_s3_v;
    logic [pts_pkg::ID_W-1:0]     r_s3_id, n_s3_id;
    pts_pkg::t_task               r_s3_task, n_s3_task;
    logic [pts_pkg::TICK_W-1:0]   r_s3_el, n_s3_el;
    logic                         r_stop, n_stop;
    logic                         r_res_valid, n_res_valid;
    pts_pkg::t_res                r_res, n_res;

    logic                         ord_we;
    logic [pts_pkg::POS_W-1:0]    ord_waddr;
    logic [pts_pkg::ID_W-1:0]     ord_wdata;
    logic [pts_pkg::POS_W-1:0]    ord_raddr;
    logic [pts_pkg::ID_W-1:0]     ord_rdata;
    logic                         tsk_we;
    logic [pts_pkg::ID_W-1:0]     tsk_waddr;
    pts_pkg::t_task               tsk_wdata;
    logic [pts_pkg::ID_W-1:0]     tsk_raddr;
    pts_pkg::t_task               tsk_rdata;
    logic [$bits(pts_pkg::t_task)-1:0] tsk_rbits;

    logic                         full;
    logic [pts_pkg::TICK_W:0]     diff;
    logic                         fire;

    // Registration order, one task identity per entry.
    pts_ram #(
        .WIDTH(pts_pkg::ID_W),
        .DEPTH(pts_pkg::MAX_TASKS)
    ) u_order (
        .i_clk  (i_clk),
        .i_we   (ord_we),
        .i_waddr(ord_waddr),
        .i_wdata(ord_wdata),
        .i_raddr(ord_raddr),
        .o_rdata(ord_rdata)
    );

    // Per-task period, enable and last-fire time, addressed by identity.
    pts_ram #(
        .WIDTH($bits(pts_pkg::t_task)),
        .DEPTH(pts_pkg::ID_COUNT)
    ) u_tasks (
        .i_clk  (i_clk),
        .i_we   (tsk_we),
        .i_waddr(tsk_waddr),
        .i_wdata(tsk_wdata),
        .i_raddr(tsk_raddr),
        .o_rdata(tsk_rbits)
    );

    assign tsk_rdata   = pts_pkg::t_task'(tsk_rbits);
    assign full        = (r_count >= pts_pkg::CNT_W'(pts_pkg::MAX_TASKS));
    assign diff        = {1'b0, r_s3_el} - {1'b0, r_s3_task.period};
    assign fire        = r_s3_v && !diff[pts_pkg::TICK_W];

    assign busy        = (r_state != pts_pkg::S_IDLE);
    assign o_cfg_ready = (r_state == pts_pkg::S_IDLE);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= pts_pkg::S_IDLE;
            r_count      <= '0;
            r_present    <= '0;
            r_first_only <= 1'b0;
            r_s1_v       <= 1'b0;
            r_s2_v       <= 1'b0;
            r_s3_v       <= 1'b0;
            r_stop       <= 1'b0;
            r_found      <= 1'b0;
            r_idx        <= '0;
            r_res_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_present   <= n_present;
            r_s1_v      <= n_s1_v;
            r_s2_v      <= n_s2_v;
            r_s3_v      <= n_s3_v;
            r_stop      <= n_stop;
            r_found     <= n_found;
            r_idx       <= n_idx;
            r_res_valid <= n_res_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_first_only <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_req     <= n_req;
        r_s1_pos  <= n_s1_pos;
        r_s2_id   <= n_s2_id;
        r_s3_id   <= n_s3_id;
        r_s3_task <= n_s3_task;
        r_s3_el   <= n_s3_el;
        r_res     <= n_res;
    end

    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_count     = r_count;
        n_present   = r_present;
        n_idx       = r_idx;
        n_s1_v      = r_s1_v;
        n_s1_pos    = r_s1_pos;
        n_found     = r_found;
        n_s2_v      = r_s2_v;
        n_s2_id     = r_s2_id;
        n_s3_v      = r_s3_v;
        n_s3_id     = r_s3_id;
        n_s3_task   = r_s3_task;
        n_s3_el     = r_s3_el;
        n_stop      = r_stop;
        n_res_valid = 1'b0;
        n_res       = r_res;

        ord_we    = 1'b0;
        ord_waddr = r_count[pts_pkg::POS_W-1:0];
        ord_wdata = r_req.task_id;
        ord_raddr = r_idx[pts_pkg::POS_W-1:0];
        tsk_we    = 1'b0;
        tsk_waddr = r_req.task_id;
        tsk_wdata = tsk_rdata;
        tsk_raddr = ord_rdata;

        unique case (r_state)
            pts_pkg::S_IDLE: begin
                // Read the named entry now so an update can merge it next cycle.
                tsk_raddr = i_req.task_id;
                if (start) begin
                    n_req = i_req;
                    n_res = '{kind: pts_pkg::K_STATUS, fired_task: '0, lateness: '0,
                              status: pts_pkg::ST_OK, last: 1'b1};
                    unique case (i_req.opcode)
                        pts_pkg::OP_TICK: begin
                            n_state = pts_pkg::S_TICK;
                            n_idx   = '0;
                            n_stop  = 1'b0;
                            n_s1_v  = 1'b0;
                            n_s2_v  = 1'b0;
                            n_s3_v  = 1'b0;
                        end
                        pts_pkg::OP_REG: begin
                            if (r_present[i_req.task_id]) begin
                                n_state = pts_pkg::S_UPDATE;
                            end else if (full) begin
                                n_res.status = pts_pkg::ST_FULL;
                                n_res_valid  = 1'b1;
                            end else begin
                                ord_we    = 1'b1;
                                ord_wdata = i_req.task_id;
                                tsk_we    = 1'b1;
                                tsk_waddr = i_req.task_id;
                                tsk_wdata = '{enable: i_req.enable, period: i_req.period,
                                              last_fire: '0};
                                n_count   = r_count + 1'b1;
                                n_present[i_req.task_id] = 1'b1;
                                n_res_valid = 1'b1;
                            end
                        end
                        pts_pkg::OP_UNREG: begin
                            if (r_present[i_req.task_id]) begin
                                n_state = pts_pkg::S_UNREG;
                                n_idx   = '0;
                                n_found = 1'b0;
                                n_s1_v  = 1'b0;
                            end else begin
                                n_res.status = pts_pkg::ST_NOT_FOUND;
                                n_res_valid  = 1'b1;
                            end
                        end
                        pts_pkg::OP_SET_EN, pts_pkg::OP_SET_PER: begin
                            if (r_present[i_req.task_id]) begin
                                n_state = pts_pkg::S_UPDATE;
                            end else begin
                                n_res.status = pts_pkg::ST_NOT_FOUND;
                                n_res_valid  = 1'b1;
                            end
                        end
                        default: begin
                            n_res_valid = 1'b1;
                        end
                    endcase
                end
            end

            pts_pkg::S_UPDATE: begin
                tsk_we = 1'b1;
                case (r_req.opcode)
                    pts_pkg::OP_REG: begin
                        tsk_wdata.enable = r_req.enable;
                        tsk_wdata.period = r_req.period;
                    end
                    pts_pkg::OP_SET_EN: begin
                        tsk_wdata.enable = r_req.enable;
                    end
                    default: begin
                        tsk_wdata.period = r_req.period;
                    end
                endcase
                n_res = '{kind: pts_pkg::K_STATUS, fired_task: '0, lateness: '0,
                          status: pts_pkg::ST_OK, last: 1'b1};
                n_res_valid = 1'b1;
                n_state     = pts_pkg::S_IDLE;
            end

            pts_pkg::S_UNREG: begin
                // Once the task is found, each later entry is written one place up.
                if (r_s1_v) begin
                    if (r_found) begin
                        ord_we    = 1'b1;
                        ord_waddr = r_s1_pos - 1'b1;
                        ord_wdata = ord_rdata;
                    end else if (ord_rdata == r_req.task_id) begin
                        n_found = 1'b1;
                    end
                end
                if (r_idx < r_count) begin
                    n_idx    = r_idx + 1'b1;
                    n_s1_v   = 1'b1;
                    n_s1_pos = r_idx[pts_pkg::POS_W-1:0];
                end else begin
                    n_s1_v = 1'b0;
                    if (!r_s1_v) begin
                        n_count = r_count - 1'b1;
                        n_present[r_req.task_id] = 1'b0;
                        n_res = '{kind: pts_pkg::K_STATUS, fired_task: '0, lateness: '0,
                                  status: pts_pkg::ST_OK, last: 1'b1};
                        n_res_valid = 1'b1;
                        n_state     = pts_pkg::S_IDLE;
                    end
                end
            end

            pts_pkg::S_TICK: begin
                // Identities in the order list are distinct, so the last-fire write
                // never targets the entry being read and needs no forwarding.
                n_s2_v  = r_s1_v && r_present[ord_rdata];
                n_s2_id = ord_rdata;

                n_s3_v    = r_s2_v && tsk_rdata.enable;
                n_s3_id   = r_s2_id;
                n_s3_task = tsk_rdata;
                n_s3_el   = r_req.tick_now - tsk_rdata.last_fire;

                if (r_idx < r_count && !r_stop) begin
                    n_idx  = r_idx + 1'b1;
                    n_s1_v = 1'b1;
                end else begin
                    n_s1_v = 1'b0;
                end

                if (fire) begin
                    tsk_we    = 1'b1;
                    tsk_waddr = r_s3_id;
                    tsk_wdata = '{enable: r_s3_task.enable, period: r_s3_task.period,
                                  last_fire: r_req.tick_now};
                    n_res = '{kind: pts_pkg::K_FIRED, fired_task: r_s3_id,
                              lateness: diff[pts_pkg::TICK_W-1:0],
                              status: pts_pkg::ST_OK, last: 1'b0};
                    n_res_valid = 1'b1;
                    if (r_first_only) begin
                        n_stop = 1'b1;
                        n_s1_v = 1'b0;
                        n_s2_v = 1'b0;
                        n_s3_v = 1'b0;
                    end
                end

                if ((r_stop || r_idx >= r_count) && !r_s1_v && !r_s2_v && !r_s3_v) begin
                    n_res = '{kind: pts_pkg::K_END, fired_task: '0, lateness: '0,
                              status: pts_pkg::ST_OK, last: 1'b1};
                    n_res_valid = 1'b1;
                    n_state     = pts_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = pts_pkg::S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_count_matches_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pts_pkg::CNT_W'($countones(r_present)) == r_count)
        else $error("task count disagrees with presence bits");

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= pts_pkg::CNT_W'(pts_pkg::MAX_TASKS))
        else $error("task count beyond table size");

    a_fired_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.kind == pts_pkg::K_FIRED) |-> !o_res.last)
        else $error("fired result marked as final");

    a_first_only_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.kind == pts_pkg::K_FIRED && r_first_only)
        |=> (o_res_valid && o_res.kind == pts_pkg::K_END))
        else $error("walk did not end after first firing");

    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.last) |-> !busy)
        else $error("still busy after final result");
`endif

endmodule
